[rtl/fpfa_pkg.sv]
// Shared types and constants for the FIFO page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package fpfa_pkg;

	localparam int PROC_W  = 8;
	localparam int PAGE_W  = 16;
	localparam int FRAME_W = 4;
	localparam int CFG_W   = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	typedef struct packed {
		logic [PROC_W-1:0] process_number;
		logic [PAGE_W-1:0] page_number;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_number;
		logic               replaced;
		logic [PROC_W-1:0]  evicted_process;
		logic [PAGE_W-1:0]  evicted_page;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RING,
		ST_FRAME
	} state_t;

endpackage
`default_nettype wire

[rtl/fifo_page_frame_allocator.sv]
// FIFO page frame allocator: free-frame search, FIFO eviction ring, frame table.
//
//   channel   signals                    transfer when
//   -------   ------------------------   ------------------------------
//   request   start, busy, request       start && !busy at clk rise
//   result    done, result               done high (one cycle, no stall)
//   config    cfg_we, cfg_wdata          cfg_we at clk rise
//
// A request that finds a free frame among the frames in use is written at
// acceptance and its result shows on the next cycle, so such requests can
// follow back to back. A request that must evict passes through ST_RING and
// ST_FRAME: the accept cycle reads the head of the order ring, ST_RING reads
// the victim's owner and page from the frame table, and ST_FRAME writes back.
// Both memory reads are registered and lie in series on this path; busy is
// high in ST_RING and ST_FRAME, and the result shows in the cycle after write
// back. Reset empties all frames (valid flops) and the ring pointers at once;
// there is no clearing pass. A config write also empties every frame. The
// receiver cannot stall, so each result is shown exactly once.
`timescale 1ns / 1ps
`default_nettype none
module fifo_page_frame_allocator #(
	parameter int MAX_FRAMES = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire fpfa_pkg::req_t          request,
	output logic                         done,
	output fpfa_pkg::rsp_t               result,
	input  wire                          cfg_we,
	input  wire  [fpfa_pkg::CFG_W-1:0]   cfg_wdata
);
	import fpfa_pkg::*;

	localparam int IW = $clog2(MAX_FRAMES);

	// frame table: {owner, page}, and order ring of frame indices
	logic [PROC_W+PAGE_W-1:0] frame_mem [MAX_FRAMES];
	logic [IW-1:0]            ring_mem  [MAX_FRAMES];

	state_t                   state_q, state_d;
	logic [CFG_W-1:0]         cfg_q;
	logic [MAX_FRAMES-1:0]    valid_q;
	logic [IW-1:0]            head_q, tail_q;
	logic [IW-1:0]            victim_q;
	logic [IW-1:0]            ring_rd_q;
	logic [PROC_W+PAGE_W-1:0] frame_rd_q;
	req_t                     req_q;
	logic                     done_q;
	rsp_t                     result_q;

	logic [IW-1:0]            last_idx;
	logic [IW-1:0]            free_idx;
	logic                     free_found;
	logic                     accept;

	// control decoded by the FSM
	logic                     fill_go;    // write a free frame now
	logic                     evict_go;   // write back the victim now
	logic                     grab_victim;
	logic                     wr_en;
	logic [IW-1:0]            wr_addr;
	logic [PROC_W+PAGE_W-1:0] wr_data;

	// highest frame index in use: 0 acts as 1, above MAX_FRAMES clamps
	always_comb begin
		if (cfg_q == '0) begin
			last_idx = '0;
		end else if (32'(cfg_q) > MAX_FRAMES) begin
			last_idx = IW'(MAX_FRAMES - 1);
		end else begin
			last_idx = IW'(cfg_q - 5'd1);
		end
	end

	// priority encoder, lowest invalid frame in use wins
	always_comb begin
		free_idx   = '0;
		free_found = 1'b0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (IW'(i) <= last_idx && !valid_q[i]) begin
				free_idx   = IW'(i);
				free_found = 1'b1;
			end
		end
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		busy        = 1'b1;
		fill_go     = 1'b0;
		evict_go    = 1'b0;
		grab_victim = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (accept) begin
					if (free_found) begin
						fill_go = 1'b1;
					end else begin
						state_d = ST_RING;
					end
				end
			end
			ST_RING: begin
				grab_victim = 1'b1;
				state_d     = ST_FRAME;
			end
			ST_FRAME: begin
				evict_go = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign wr_en   = fill_go || evict_go;
	assign wr_addr = fill_go ? free_idx : victim_q;
	assign wr_data = fill_go ? {request.process_number, request.page_number}
	                         : {req_q.process_number, req_q.page_number};

	// memories: one write port each, reads registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			frame_mem[wr_addr] <= wr_data;
			ring_mem[tail_q]   <= wr_addr;
		end
		ring_rd_q  <= ring_mem[head_q];
		// ring_rd_q holds the victim while in ST_RING
		frame_rd_q <= frame_mem[ring_rd_q];
	end

	// pointers, valid bits, config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= CFG_RESET;
			valid_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= wr_en;
			if (cfg_we) begin
				// new ring geometry: empty everything
				cfg_q   <= cfg_wdata;
				valid_q <= '0;
				head_q  <= '0;
				tail_q  <= '0;
			end else begin
				if (fill_go) begin
					valid_q[free_idx] <= 1'b1;
				end
				if (wr_en) begin
					tail_q <= (tail_q == last_idx) ? '0 : tail_q + 1'b1;
				end
				if (evict_go) begin
					head_q <= (head_q == last_idx) ? '0 : head_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (grab_victim) begin
			victim_q <= ring_rd_q;
		end
		if (fill_go) begin
			result_q.frame_number    <= FRAME_W'(free_idx);
			result_q.replaced        <= 1'b0;
			result_q.evicted_process <= '0;
			result_q.evicted_page    <= '0;
		end else if (evict_go) begin
			result_q.frame_number    <= FRAME_W'(victim_q);
			result_q.replaced        <= 1'b1;
			result_q.evicted_process <= frame_rd_q[PROC_W+PAGE_W-1:PAGE_W];
			result_q.evicted_page    <= frame_rd_q[PAGE_W-1:0];
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

[rtl/fpfa_checker.sv]
// Port-level checker for the FIFO page frame allocator, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module fpfa_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 start,
	input wire                 busy,
	input wire                 done,
	input wire fpfa_pkg::rsp_t result
);
	import fpfa_pkg::*;

	// an accepted request either finishes next cycle or starts an eviction
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted request neither done nor busy next cycle");

	// an eviction holds busy through ST_RING and ST_FRAME, then delivers its transfer
	a_evict_len: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |=> busy ##1 (!busy && done && result.replaced))
		else $error("eviction sequence length or result wrong");

	// no transfer while an eviction is in flight
	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result while busy");

	// free-frame results carry no evicted owner
	a_free_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.replaced |-> result.evicted_process == '0
			&& result.evicted_page == '0)
		else $error("evicted owner not zero on free frame");

endmodule

bind fifo_page_frame_allocator fpfa_checker u_fpfa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire

[tb/sv/fifo_page_frame_allocator_tb.sv]
// Testbench for the FIFO page frame allocator: random load requests checked against a frame table model.
`timescale 1ns / 1ps
module fifo_page_frame_allocator_tb;
	import fpfa_pkg::*;

	localparam int MAX_FRAMES    = 16;
	localparam int SETTLE_CYCLES = 6;       // covers the eviction path through ST_RING and ST_FRAME, plus margin
	localparam int LOAD_TARGET   = 1850;
	localparam int CYCLE_LIMIT   = 400000;

	// Work items for the driver: a page load, a frame count write, or a pause
	// until every expected result has come back.
	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SET_FRAMES,
		OP_SETTLE
	} op_kind_t;

	typedef struct {
		op_kind_t         kind;
		req_t             rq;
		logic [CFG_W-1:0] frames;
	} op_t;

	logic             clk;
	logic             arst_n;
	logic             start     = 1'b0;
	logic             busy;
	req_t             request   = '0;
	logic             done;
	rsp_t             result;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	fifo_page_frame_allocator #(.MAX_FRAMES(MAX_FRAMES)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Frame table model state.
	logic [CFG_W-1:0]  frames_cfg;
	logic              slot_valid [MAX_FRAMES];
	logic [PROC_W-1:0] slot_owner [MAX_FRAMES];
	logic [PAGE_W-1:0] slot_page  [MAX_FRAMES];
	int                fifo_order [MAX_FRAMES];
	int                fifo_head;
	int                fifo_tail;
	int                fifo_count;

	op_t  ops_q[$];
	rsp_t pending_rsp_q[$];

	int load_count;
	int mismatch_count;
	int cycle_count;
	int quiet_cycles;
	int burst_left;
	int gap_left;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// A frame count write also empties every frame and the order ring.
	function automatic void load_frame_count(logic [CFG_W-1:0] value);
		frames_cfg = value;
		fifo_head  = 0;
		fifo_tail  = 0;
		fifo_count = 0;
		for (int i = 0; i < MAX_FRAMES; i++)
			slot_valid[i] = 1'b0;
	endfunction

	// Every request is a fault: lowest free frame first, else evict the oldest.
	function automatic rsp_t alloc_frame(req_t rq);
		int   n;
		int   victim;
		rsp_t r;
		n = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : int'(frames_cfg));
		victim = n;
		r = '0;
		for (int i = n - 1; i >= 0; i--)
			if (!slot_valid[i])
				victim = i;
		if (victim == n) begin
			victim = fifo_order[fifo_head % n] % n;
			fifo_head = (fifo_head % n + 1) % n;
			if (fifo_count > 0)
				fifo_count--;
			r.replaced        = 1'b1;
			r.evicted_process = slot_owner[victim];
			r.evicted_page    = slot_page[victim];
		end
		slot_owner[victim] = rq.process_number;
		slot_page[victim]  = rq.page_number;
		slot_valid[victim] = 1'b1;
		fifo_order[fifo_tail % n] = victim;
		fifo_tail = (fifo_tail % n + 1) % n;
		if (fifo_count < n)
			fifo_count++;
		r.frame_number = FRAME_W'(victim);
		return r;
	endfunction

	task automatic add_load(logic [PROC_W-1:0] proc, logic [PAGE_W-1:0] page);
		op_t op;
		op.kind   = OP_LOAD;
		op.rq     = '{process_number: proc, page_number: page};
		op.frames = '0;
		ops_q.push_back(op);
		load_count++;
	endtask

	task automatic add_control(op_kind_t kind, logic [CFG_W-1:0] value);
		op_t op;
		op.kind   = kind;
		op.rq     = '0;
		op.frames = value;
		ops_q.push_back(op);
	endtask

	// Stimulus: directed corners first, then random phases under varied frame counts.
	initial begin
		logic [CFG_W-1:0]  frames;
		logic [PROC_W-1:0] proc;
		logic [PAGE_W-1:0] page;
		int                phase_len;
		load_count     = 0;
		mismatch_count = 0;
		cycle_count    = 0;
		quiet_cycles   = 0;
		burst_left     = 1;
		gap_left       = 0;
		load_frame_count(CFG_RESET);

		// fill all sixteen frames from reset, owner and page walking the extremes
		for (int i = 0; i < MAX_FRAMES; i++)
			add_load(PROC_W'(i * 17), (i % 2 == 0) ? {PAGE_W{1'b0}} : {PAGE_W{1'b1}});
		// table full: evictions come from the head of the ring
		add_load(8'hFF, 16'hFFFF);
		add_load(8'h00, 16'h0000);
		add_load(8'hA5, 16'h5A5A);
		add_control(OP_SETTLE, '0);
		// zero frames acts as one: every request after the first evicts frame 0
		add_control(OP_SET_FRAMES, 5'd0);
		add_load(8'h3C, 16'h8001);
		add_load(8'hC3, 16'h7FFE);
		// count above the frame limit clamps to sixteen
		add_control(OP_SET_FRAMES, 5'd31);
		add_load(8'h80, 16'h8000);
		add_load(8'h01, 16'h0001);

		while (load_count < LOAD_TARGET) begin
			case ($urandom_range(0, 9))
				0:       frames = 5'd0;
				1:       frames = 5'd1;
				2:       frames = 5'd2;
				3:       frames = 5'd16;
				4:       frames = CFG_W'($urandom_range(17, 31));
				default: frames = CFG_W'($urandom_range(1, 16));
			endcase
			add_control(OP_SET_FRAMES, frames);
			phase_len = $urandom_range(10, 120);
			repeat (phase_len) begin
				if ($urandom_range(0, 60) == 0)
					add_control(OP_SETTLE, '0);
				proc = PROC_W'($urandom_range(0, 255));
				page = PAGE_W'($urandom_range(0, 65535));
				if ($urandom_range(0, 7) == 0)
					proc = $urandom_range(0, 1) ? {PROC_W{1'b1}} : {PROC_W{1'b0}};
				if ($urandom_range(0, 7) == 0)
					page = $urandom_range(0, 1) ? {PAGE_W{1'b1}} : {PAGE_W{1'b0}};
				add_load(proc, page);
			end
		end

		while (ops_q.size() != 0 || start || pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
			$display("fifo_page_frame_allocator test passed");
		end else begin
			$display("fifo_page_frame_allocator test failed");
		end
		$finish;
	end

	// Driver: bursts of requests with random gaps; frame count writes and
	// pauses wait until quiet_cycles reaches SETTLE_CYCLES.
	always @(posedge clk) begin : driver
		logic             next_start;
		req_t             next_req;
		logic             next_we;
		logic [CFG_W-1:0] next_wdata;
		op_t              op;
		next_start = start;
		next_req   = request;
		next_we    = 1'b0;
		next_wdata = cfg_wdata;
		if (arst_n) begin
			// request transfer
			if (start && !busy) begin
				pending_rsp_q.push_back(alloc_frame(request));
				next_start = 1'b0;
			end
			// a result on this edge means the monitor is popping; not quiet
			if (pending_rsp_q.size() == 0 && !done && !start)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!next_start && ops_q.size() != 0) begin
				if (gap_left != 0) begin
					gap_left--;
				end else begin
					op = ops_q[0];
					if (op.kind == OP_LOAD) begin
						next_start = 1'b1;
						next_req   = op.rq;
						void'(ops_q.pop_front());
						if (burst_left > 1) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 48);
							case ($urandom_range(0, 7))
								0:       gap_left = $urandom_range(10, 24);
								1, 2, 3: gap_left = $urandom_range(1, 4);
								default: gap_left = 0;
							endcase
						end
					end else if (quiet_cycles >= SETTLE_CYCLES) begin
						if (op.kind == OP_SET_FRAMES) begin
							next_we    = 1'b1;
							next_wdata = op.frames;
							load_frame_count(op.frames);
							// keep the next request off the write edge
							gap_left = 1;
						end
						void'(ops_q.pop_front());
					end
				end
			end
		end
		start     <= next_start;
		request   <= next_req;
		cfg_we    <= next_we;
		cfg_wdata <= next_wdata;
	end

	// Monitor: every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: frame %0d replaced %0b proc %0d page %0d",
						result.frame_number, result.replaced,
						result.evicted_process, result.evicted_page);
			end else begin
				want = pending_rsp_q.pop_front();
				if (result.frame_number !== want.frame_number ||
					result.replaced !== want.replaced ||
					result.evicted_process !== want.evicted_process ||
					result.evicted_page !== want.evicted_page) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected frame %0d replaced %0b proc %0d page %0d, got frame %0d replaced %0b proc %0d page %0d",
							want.frame_number, want.replaced,
							want.evicted_process, want.evicted_page,
							result.frame_number, result.replaced,
							result.evicted_process, result.evicted_page);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("fifo_page_frame_allocator test failed");
			$finish;
		end
	end

endmodule

[sim.f]
rtl/fpfa_pkg.sv
rtl/fifo_page_frame_allocator.sv
rtl/fpfa_checker.sv
tb/sv/fifo_page_frame_allocator_tb.sv
